### rtl/two_line_fit_intersection_unit_assert.svh
// ----------------------------------------------------------------------------
// Two-line fit intersection unit - assertion macros
// Shared property forms for the fit unit checks.
// ----------------------------------------------------------------------------
`ifndef TWO_LINE_FIT_INTERSECTION_UNIT_ASSERT_SVH
`define TWO_LINE_FIT_INTERSECTION_UNIT_ASSERT_SVH

// same-cycle implication
`define TLFI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLFI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tlfi_pkg.sv
// ----------------------------------------------------------------------------
// Two-line fit intersection package
// Wide arithmetic type, shared unit control and saturation helpers.
// ----------------------------------------------------------------------------
package tlfi_pkg;

  localparam int WW        = 128;
  localparam int MUL_STEPS = 64;
  localparam int DIV_STEPS = 128;
  localparam int STEP_W    = 8;

  typedef logic signed [WW-1:0] wide_t;

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_VERT_DEG = 3'd1,
    STAT_HOR_DEG  = 3'd2,
    STAT_PARALLEL = 3'd3,
    STAT_OVERFLOW = 3'd4
  } status_t;

  localparam wide_t S48_MAX = (wide_t'(1) <<< 47) - wide_t'(1);
  localparam wide_t S48_MIN = -(wide_t'(1) <<< 47);
  localparam wide_t S16_MAX = (wide_t'(1) <<< 15) - wide_t'(1);
  localparam wide_t S16_MIN = -(wide_t'(1) <<< 15);

  function automatic logic signed [47:0] sat48(input wide_t v);
    logic signed [47:0] r;
    if (v > S48_MAX) r = S48_MAX[47:0];
    else if (v < S48_MIN) r = S48_MIN[47:0];
    else r = v[47:0];
    return r;
  endfunction

  function automatic logic signed [15:0] sat16(input wide_t v);
    logic signed [15:0] r;
    if (v > S16_MAX) r = S16_MAX[15:0];
    else if (v < S16_MIN) r = S16_MIN[15:0];
    else r = v[15:0];
    return r;
  endfunction

endpackage

### rtl/tlfi_alu.sv
// ----------------------------------------------------------------------------
// Two-line fit intersection - shared arithmetic unit
// Signed shift-add multiply and signed rounded restoring divide, one bit
// per cycle over a single wide adder/subtractor.
// ----------------------------------------------------------------------------
module tlfi_alu (
  input  logic             clk,
  input  logic             rst,
  input  tlfi_pkg::alu_ctl_t ctl,
  input  tlfi_pkg::wide_t  opa,
  input  tlfi_pkg::wide_t  opb,
  output logic             busy,
  output logic             done,
  output tlfi_pkg::wide_t  res
);

  localparam int WW = tlfi_pkg::WW;

  logic [tlfi_pkg::STEP_W-1:0] cnt;
  tlfi_pkg::alu_op_t op;
  logic            neg;
  logic [WW-1:0]   rem, quo, dvs;
  logic [WW-1:0]   mag_a, mag_b, r2, mag_res;
  logic            ge;

  always_comb begin
    mag_a   = opa[WW-1] ? WW'(-opa) : WW'(opa);
    mag_b   = opb[WW-1] ? WW'(-opb) : WW'(opb);
    r2      = {rem[WW-2:0], quo[WW-1]};
    ge      = (r2 >= dvs);
    mag_res = (op == tlfi_pkg::OP_MUL) ? rem : quo;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        op   <= ctl.op;
        neg  <= opa[WW-1] ^ opb[WW-1];
        rem  <= '0;
        if (ctl.op == tlfi_pkg::OP_MUL) begin
          dvs <= mag_a;
          quo <= mag_b;
          cnt <= tlfi_pkg::STEP_W'(tlfi_pkg::MUL_STEPS);
        end else begin
          dvs <= mag_b << 1;
          quo <= (mag_a << 1) + mag_b;
          cnt <= tlfi_pkg::STEP_W'(tlfi_pkg::DIV_STEPS);
        end
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
          if (op == tlfi_pkg::OP_MUL) begin
            if (quo[0]) rem <= rem + dvs;
            dvs <= dvs << 1;
            quo <= quo >> 1;
          end else begin
            rem <= ge ? (r2 - dvs) : r2;
            quo <= {quo[WW-2:0], ge};
          end
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
          res  <= neg ? tlfi_pkg::wide_t'(-mag_res) : tlfi_pkg::wide_t'(mag_res);
        end
      end
    end
  end

endmodule

### rtl/two_line_fit_intersection_unit.sv
// ----------------------------------------------------------------------------
// Two-line fit intersection unit
// Least-squares fit of two point sets and their crossing point.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake                 | payload
//  point    | in        | point_valid / point_stall | point_x, point_y, which_line,
//           |           |                           | last_point
//  result   | out       | result_valid/result_stall | slopes, offsets, cross, status
//
// A point beat without last_point is taken while collecting, without stalling.
// last_point starts the fit: up to 14 multiplies and 6 divides on the shared unit.
// point_stall is high for the whole fit and while a result waits to load.
// Synchronous reset clears the accumulators, the sequencer and result_valid.
// ----------------------------------------------------------------------------
`include "two_line_fit_intersection_unit_assert.svh"

module two_line_fit_intersection_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  output logic               point_stall,
  input  logic [11:0]        point_x,
  input  logic [11:0]        point_y,
  input  logic               which_line,
  input  logic               last_point,
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [47:0] vert_slope,
  output logic signed [47:0] vert_offset,
  output logic signed [47:0] horiz_slope,
  output logic signed [47:0] horiz_offset,
  output logic signed [15:0] cross_x,
  output logic signed [15:0] cross_y,
  output logic [2:0]         status
);

  localparam int CU   = (COORD_BITS < 12) ? COORD_BITS : 12;
  localparam int CNTW = $clog2(MAX_POINTS + 1);
  localparam int LINW = CU + CNTW;
  localparam int SQW  = 2 * CU + CNTW;

  typedef enum logic [2:0] {ST_ACC, ST_ISSUE, ST_WAIT, ST_CHK, ST_DONE} state_t;
  typedef enum logic [3:0] {
    K_D1, K_D2, K_A1, K_A2, K_B1, K_B2, K_S, K_O, K_CX, K_Y1, K_Y2, K_CY
  } step_t;

  state_t state;
  step_t  step;
  logic   fset, vok, hok, par, ovf;

  logic [CNTW-1:0] vcount, hcount;
  logic [LINW-1:0] vsx, vsy, hsx, hsy;
  logic [SQW-1:0]  vsq, vcross, hsq, hcross;

  tlfi_pkg::wide_t t1, d, a, b;
  logic signed [47:0] p1, q1, p2, q2;
  logic signed [15:0] cx, cy;

  logic [CU-1:0]   xc, yc;
  logic [2*CU-1:0] prod_xy, prod_xx, prod_yy;
  logic            accept, vfull, hfull, out_free;

  tlfi_pkg::wide_t n_w, su_w, sv_w, suu_w, suv_w, den, dq, opa, opb, res;
  tlfi_pkg::alu_ctl_t ctl;
  logic alu_busy, alu_done;

  assign point_stall = (state != ST_ACC);
  assign accept      = point_valid && !point_stall;
  assign out_free    = !result_valid || !result_stall;
  assign xc          = point_x[CU-1:0];
  assign yc          = point_y[CU-1:0];
  assign prod_xy     = xc * yc;
  assign prod_xx     = xc * xc;
  assign prod_yy     = yc * yc;
  assign vfull       = (vcount >= CNTW'(MAX_POINTS));
  assign hfull       = (hcount >= CNTW'(MAX_POINTS));

  always_comb begin
    if (!fset) begin
      n_w   = tlfi_pkg::wide_t'(vcount);
      su_w  = tlfi_pkg::wide_t'(vsy);
      sv_w  = tlfi_pkg::wide_t'(vsx);
      suu_w = tlfi_pkg::wide_t'(vsq);
      suv_w = tlfi_pkg::wide_t'(vcross);
    end else begin
      n_w   = tlfi_pkg::wide_t'(hcount);
      su_w  = tlfi_pkg::wide_t'(hsx);
      sv_w  = tlfi_pkg::wide_t'(hsy);
      suu_w = tlfi_pkg::wide_t'(hsq);
      suv_w = tlfi_pkg::wide_t'(hcross);
    end
    den = tlfi_pkg::wide_t'(p1) - tlfi_pkg::wide_t'(p2);
    dq  = tlfi_pkg::wide_t'(q2) - tlfi_pkg::wide_t'(q1);
  end

  always_comb begin
    opa    = '0;
    opb    = '0;
    ctl.op = tlfi_pkg::OP_MUL;
    case (step)
      K_D1: begin opa = n_w;  opb = suu_w; end
      K_D2: begin opa = su_w; opb = su_w;  end
      K_A1: begin opa = n_w;  opb = suv_w; end
      K_A2: begin opa = su_w; opb = sv_w;  end
      K_B1: begin opa = suu_w; opb = sv_w; end
      K_B2: begin opa = su_w; opb = suv_w; end
      K_S: begin
        ctl.op = tlfi_pkg::OP_DIV;
        opa    = fset ? (a <<< FRAC_BITS) : (d <<< FRAC_BITS);
        opb    = fset ? d : a;
      end
      K_O: begin
        ctl.op = tlfi_pkg::OP_DIV;
        opa    = fset ? (b <<< FRAC_BITS) : -(b <<< FRAC_BITS);
        opb    = fset ? d : a;
      end
      K_CX: begin ctl.op = tlfi_pkg::OP_DIV; opa = dq; opb = den; end
      K_Y1: begin opa = tlfi_pkg::wide_t'(p1); opb = dq;  end
      K_Y2: begin opa = tlfi_pkg::wide_t'(q1); opb = den; end
      K_CY: begin ctl.op = tlfi_pkg::OP_DIV; opa = t1; opb = den <<< FRAC_BITS; end
      default: begin opa = '0; opb = '0; end
    endcase
    ctl.start = (state == ST_ISSUE);
  end

  tlfi_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .opa  (opa),
    .opb  (opb),
    .busy (alu_busy),
    .done (alu_done),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_ACC;
      step         <= K_D1;
      fset         <= 1'b0;
      vok          <= 1'b0;
      hok          <= 1'b0;
      par          <= 1'b0;
      ovf          <= 1'b0;
      result_valid <= 1'b0;
      vcount <= '0; vsx <= '0; vsy <= '0; vsq <= '0; vcross <= '0;
      hcount <= '0; hsx <= '0; hsy <= '0; hsq <= '0; hcross <= '0;
    end else begin
      if ((state != ST_DONE) && result_valid && !result_stall) result_valid <= 1'b0;
      case (state)
        ST_ACC: begin
          if (accept) begin
            if (!which_line) begin
              if (vfull) ovf <= 1'b1;
              else begin
                vcount <= vcount + 1'b1;
                vsx    <= vsx + LINW'(xc);
                vsy    <= vsy + LINW'(yc);
                vsq    <= vsq + SQW'(prod_yy);
                vcross <= vcross + SQW'(prod_xy);
              end
            end else begin
              if (hfull) ovf <= 1'b1;
              else begin
                hcount <= hcount + 1'b1;
                hsx    <= hsx + LINW'(xc);
                hsy    <= hsy + LINW'(yc);
                hsq    <= hsq + SQW'(prod_xx);
                hcross <= hcross + SQW'(prod_xy);
              end
            end
            if (last_point) begin
              state <= ST_ISSUE;
              step  <= K_D1;
              fset  <= 1'b0;
              vok   <= 1'b0;
              hok   <= 1'b0;
              par   <= 1'b0;
              p1 <= '0; q1 <= '0; p2 <= '0; q2 <= '0; cx <= '0; cy <= '0;
            end
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (alu_done) begin
            case (step)
              K_D1: begin t1 <= res; step <= K_D2; state <= ST_ISSUE; end
              K_D2: begin d <= t1 - res; step <= K_A1; state <= ST_ISSUE; end
              K_A1: begin t1 <= res; step <= K_A2; state <= ST_ISSUE; end
              K_A2: begin a <= t1 - res; step <= K_B1; state <= ST_ISSUE; end
              K_B1: begin t1 <= res; step <= K_B2; state <= ST_ISSUE; end
              K_B2: begin
                b <= t1 - res;
                if (!fset) begin
                  vok   <= (d != '0) && (a != '0);
                  state <= ST_ISSUE;
                  if ((d != '0) && (a != '0)) step <= K_S;
                  else begin
                    fset <= 1'b1;
                    step <= K_D1;
                  end
                end else begin
                  hok <= (d != '0);
                  if (d != '0) begin
                    step  <= K_S;
                    state <= ST_ISSUE;
                  end else state <= ST_CHK;
                end
              end
              K_S: begin
                if (fset) p2 <= tlfi_pkg::sat48(res);
                else p1 <= tlfi_pkg::sat48(res);
                step  <= K_O;
                state <= ST_ISSUE;
              end
              K_O: begin
                if (fset) begin
                  q2    <= tlfi_pkg::sat48(res);
                  state <= ST_CHK;
                end else begin
                  q1    <= tlfi_pkg::sat48(res);
                  fset  <= 1'b1;
                  step  <= K_D1;
                  state <= ST_ISSUE;
                end
              end
              K_CX: begin cx <= tlfi_pkg::sat16(res); step <= K_Y1; state <= ST_ISSUE; end
              K_Y1: begin t1 <= res; step <= K_Y2; state <= ST_ISSUE; end
              K_Y2: begin t1 <= t1 + res; step <= K_CY; state <= ST_ISSUE; end
              K_CY: begin cy <= tlfi_pkg::sat16(res); state <= ST_DONE; end
              default: state <= ST_DONE;
            endcase
          end
        end
        ST_CHK: begin
          if (!vok || !hok) state <= ST_DONE;
          else if (den == '0) begin
            par   <= 1'b1;
            state <= ST_DONE;
          end else begin
            step  <= K_CX;
            state <= ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            result_valid <= 1'b1;
            vert_slope   <= p1;
            vert_offset  <= q1;
            horiz_slope  <= p2;
            horiz_offset <= q2;
            cross_x      <= cx;
            cross_y      <= cy;
            if (ovf) status <= tlfi_pkg::STAT_OVERFLOW;
            else if (!vok) status <= tlfi_pkg::STAT_VERT_DEG;
            else if (!hok) status <= tlfi_pkg::STAT_HOR_DEG;
            else if (par) status <= tlfi_pkg::STAT_PARALLEL;
            else status <= tlfi_pkg::STAT_OK;
            ovf <= 1'b0;
            vcount <= '0; vsx <= '0; vsy <= '0; vsq <= '0; vcross <= '0;
            hcount <= '0; hsx <= '0; hsy <= '0; hsq <= '0; hcross <= '0;
            state <= ST_ACC;
          end
        end
        default: state <= ST_ACC;
      endcase
    end
  end

  `TLFI_ASSERT_NOW(a_done_in_wait, alu_done, state == ST_WAIT, "unit done outside wait")
  `TLFI_ASSERT_NOW(a_idle_unit, state == ST_ACC, !alu_busy, "unit busy while collecting")
  `TLFI_ASSERT_NOW(a_count_cap, 1'b1,
    (vcount <= CNTW'(MAX_POINTS)) && (hcount <= CNTW'(MAX_POINTS)), "count past cap")
  `TLFI_ASSERT_NEXT(a_clear_after_result, (state == ST_DONE) && out_free,
    (vcount == '0) && (hcount == '0) && !ovf && result_valid, "accumulators not cleared")

endmodule

### tb/two_line_fit_intersection_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-line fit intersection unit - checker
// Watches the point and result channels, keeps its own line-fit accumulators,
// predicts each fit result on a last-point beat and compares result beats
// field by field, in order, against the predicted fits.
// ----------------------------------------------------------------------------
module two_line_fit_intersection_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               point_valid,
  input  logic               point_stall,
  input  logic [11:0]        point_x,
  input  logic [11:0]        point_y,
  input  logic               which_line,
  input  logic               last_point,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [47:0] vert_slope,
  input  logic signed [47:0] vert_offset,
  input  logic signed [47:0] horiz_slope,
  input  logic signed [47:0] horiz_offset,
  input  logic signed [15:0] cross_x,
  input  logic signed [15:0] cross_y,
  input  logic [2:0]         status,
  output int                 errors,
  output int                 pending
);

  localparam int MAX_PTS = 1024;
  localparam int FB      = 16;

  typedef struct {
    logic signed [47:0] vs, vo, hs, ho;
    logic signed [15:0] cx, cy;
    tlfi_pkg::status_t  st;
  } fit_result_t;

  fit_result_t fits_due[$];

  tlfi_pkg::wide_t v_n, v_sx, v_sy, v_syy, v_sxy;
  tlfi_pkg::wide_t h_n, h_sx, h_sy, h_sxx, h_sxy;
  logic  ovf;

  function automatic tlfi_pkg::wide_t round_div(tlfi_pkg::wide_t n, tlfi_pkg::wide_t d);
    tlfi_pkg::wide_t an, ad, q;
    an = (n < 0) ? -n : n;
    ad = (d < 0) ? -d : d;
    q  = ((an <<< 1) + ad) / (ad <<< 1);
    return ((n < 0) != (d < 0)) ? -q : q;
  endfunction

  function automatic tlfi_pkg::wide_t clip(tlfi_pkg::wide_t v, int bits);
    tlfi_pkg::wide_t hi, lo;
    hi = (tlfi_pkg::wide_t'(1) <<< (bits - 1)) - 1;
    lo = -(tlfi_pkg::wide_t'(1) <<< (bits - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic fit_result_t predict_fit();
    fit_result_t r;
    tlfi_pkg::wide_t d, a, b, p1, q1, p2, q2, den, dq;
    logic vok, hok;
    p1 = 0; q1 = 0; p2 = 0; q2 = 0;
    r.cx = 0; r.cy = 0; r.st = tlfi_pkg::STAT_OK;
    // vertical set: u = y, v = x
    d = v_n * v_syy - v_sy * v_sy;
    a = v_n * v_sxy - v_sy * v_sx;
    b = v_syy * v_sx - v_sy * v_sxy;
    vok = (d != 0) && (a != 0);
    if (vok) begin
      p1 = clip(round_div(d <<< FB, a), 48);
      q1 = clip(round_div(-(b <<< FB), a), 48);
    end
    d = h_n * h_sxx - h_sx * h_sx;
    a = h_n * h_sxy - h_sx * h_sy;
    b = h_sxx * h_sy - h_sx * h_sxy;
    hok = (d != 0);
    if (hok) begin
      p2 = clip(round_div(a <<< FB, d), 48);
      q2 = clip(round_div(b <<< FB, d), 48);
    end
    if (!vok) r.st = tlfi_pkg::STAT_VERT_DEG;
    else if (!hok) r.st = tlfi_pkg::STAT_HOR_DEG;
    else begin
      den = p1 - p2;
      if (den == 0) r.st = tlfi_pkg::STAT_PARALLEL;
      else begin
        dq = q2 - q1;
        r.cx = 16'(clip(round_div(dq, den), 16));
        r.cy = 16'(clip(round_div(p1 * dq + q1 * den, den <<< FB), 16));
      end
    end
    if (ovf) r.st = tlfi_pkg::STAT_OVERFLOW;
    r.vs = p1[47:0]; r.vo = q1[47:0]; r.hs = p2[47:0]; r.ho = q2[47:0];
    return r;
  endfunction

  task automatic clear_sums();
    v_n = 0; v_sx = 0; v_sy = 0; v_syy = 0; v_sxy = 0;
    h_n = 0; h_sx = 0; h_sy = 0; h_sxx = 0; h_sxy = 0;
    ovf = 0;
  endtask

  task automatic chk(string nm, longint e, longint a);
    if (e !== a) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
    end
  endtask

  always @(posedge clk) begin
    fit_result_t e;
    tlfi_pkg::wide_t x, y;
    if (rst) begin
      clear_sums();
      fits_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (fits_due.size() == 0) begin
          errors++;
          $display("%0t: result beat with no fit due, expected none, got status %0d",
                   $time, status);
        end else begin
          e = fits_due.pop_front();
          chk("vert_slope", e.vs, vert_slope);
          chk("vert_offset", e.vo, vert_offset);
          chk("horiz_slope", e.hs, horiz_slope);
          chk("horiz_offset", e.ho, horiz_offset);
          chk("cross_x", e.cx, cross_x);
          chk("cross_y", e.cy, cross_y);
          chk("status", e.st, status);
        end
      end
      if (point_valid && !point_stall) begin
        x = tlfi_pkg::wide_t'(point_x);
        y = tlfi_pkg::wide_t'(point_y);
        if (!which_line) begin
          if (v_n >= MAX_PTS) ovf = 1;
          else begin
            v_n++; v_sx += x; v_sy += y; v_syy += y * y; v_sxy += x * y;
          end
        end else begin
          if (h_n >= MAX_PTS) ovf = 1;
          else begin
            h_n++; h_sx += x; h_sy += y; h_sxx += x * x; h_sxy += x * y;
          end
        end
        if (last_point) begin
          fits_due.push_back(predict_fit());
          clear_sums();
        end
      end
    end
    pending = fits_due.size();
  end

endmodule

### tb/two_line_fit_intersection_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-line fit intersection unit - testbench top
// Drives point jobs (directed corner cases, then noisy random lines) with
// random sender and receiver idling, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module two_line_fit_intersection_unit_tb;

  localparam int WATCHDOG = 20000;

  logic               clk = 0;
  logic               rst = 1;
  logic               point_valid = 0;
  logic               point_stall;
  logic [11:0]        point_x = 0;
  logic [11:0]        point_y = 0;
  logic               which_line = 0;
  logic               last_point = 0;
  logic               result_valid;
  logic               result_stall = 0;
  logic signed [47:0] vert_slope, vert_offset, horiz_slope, horiz_offset;
  logic signed [15:0] cross_x, cross_y;
  logic [2:0]         status;
  int                 errors, pending;

  int   send_idle = 0;
  int   recv_idle = 0;
  logic hold_req  = 0;
  int   beats_sent = 0;
  int   quiet = 0;

  always #4 clk = ~clk;

  two_line_fit_intersection_unit dut (.*);

  two_line_fit_intersection_unit_checker chk_u (.*);

  // result side: random stall, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        result_stall <= 1;
        repeat (3000) @(posedge clk);
        hold_req = 0;
      end
      result_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  always @(posedge clk) begin
    if (rst || (point_valid && !point_stall) || (result_valid && !result_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_point(input int x, input int y, input bit w, input bit l);
    if ($urandom_range(99) < send_idle) begin
      point_valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    point_valid <= 1;
    point_x     <= 12'(x);
    point_y     <= 12'(y);
    which_line  <= w;
    last_point  <= l;
    @(posedge clk);
    while (point_stall) @(posedge clk);
    beats_sent++;
  endtask

  // stop offering and wait until every predicted result has arrived
  task automatic drain();
    point_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
  endtask

  function automatic int clamp_coord(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // one job of noisy lines: nv points on the steep set, nh on the other
  task automatic line_job(input int nv, input int nh);
    int vb, hb, vk, hk, amp, t, u, left_v, left_h;
    bit w, raw;
    vb = $urandom_range(4095); hb = $urandom_range(4095);
    vk = $urandom_range(32) - 16; hk = $urandom_range(32) - 16;
    case ($urandom_range(2))
      0: amp = 0;
      1: amp = 3;
      default: amp = 60;
    endcase
    raw = ($urandom_range(7) == 0);
    left_v = nv; left_h = nh;
    while (left_v + left_h > 0) begin
      w = (left_v == 0) ? 1 : (left_h == 0) ? 0 : $urandom_range(1);
      if (w) left_h--; else left_v--;
      t = $urandom_range(4095);
      u = clamp_coord((w ? hb : vb) + (w ? hk : vk) * (t - 2048) / 8
                      + $urandom_range(2 * amp) - amp);
      if (raw) u = $urandom_range(4095);
      if (w) send_point(t, u, 1, left_v + left_h == 0);
      else send_point(u, t, 0, left_v + left_h == 0);
    end
  endtask

  task automatic random_jobs(input int upto);
    while (beats_sent < upto) begin
      if ($urandom_range(9) == 0) line_job($urandom_range(0, 3), $urandom_range(0, 3));
      else line_job($urandom_range(2, 12), $urandom_range(2, 12));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // clean crossing lines, extreme coordinates
    send_point(0, 0, 0, 0);
    send_point(4095, 4095, 1, 0);
    send_point(1, 4095, 0, 0);
    send_point(0, 4095, 1, 1);
    // steep set with equal y everywhere (vertical degenerate)
    send_point(10, 7, 0, 0);
    send_point(20, 7, 0, 0);
    send_point(5, 5, 1, 0);
    send_point(9, 30, 1, 1);
    // steep set with constant x (slope term zero)
    send_point(100, 1, 0, 0);
    send_point(100, 900, 0, 0);
    send_point(3, 3, 1, 1);
    // other set with equal x (other degenerate)
    send_point(0, 0, 0, 0);
    send_point(3, 1, 0, 0);
    send_point(50, 0, 1, 0);
    send_point(50, 4095, 1, 1);
    // parallel lines of slope one
    send_point(0, 0, 0, 0);
    send_point(1, 1, 0, 0);
    send_point(0, 5, 1, 0);
    send_point(1, 6, 1, 1);
    // steep set against a nearly flat set
    send_point(2048, 0, 0, 0);
    send_point(2049, 4095, 0, 0);
    send_point(0, 0, 1, 0);
    send_point(4095, 1, 1, 1);
    // lone last point on empty sets
    send_point(4095, 0, 1, 1);

    // overflow: more than a full set of steep points
    for (int i = 0; i < 1030; i++)
      send_point($urandom_range(4095), $urandom_range(4095), 0, 0);
    send_point(7, 9, 1, 0);
    send_point(4000, 12, 1, 1);
    drain();

    send_idle = 17; recv_idle = 88;
    random_jobs(beats_sent + 330);
    // receiver holds off while the sender keeps offering
    hold_req = 1;
    random_jobs(beats_sent + 60);
    drain();
    send_idle = 88; recv_idle = 17;
    random_jobs(beats_sent + 330);
    drain();
    send_idle = 0; recv_idle = 0;
    random_jobs(beats_sent + 330);

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
